[rtl/per_agent_transition_counter_core_macros.svh]
// Assertion macros for the transition counter core.
// Both expect clk and arst_n in the scope where they are used.
`ifndef PER_AGENT_TRANSITION_COUNTER_CORE_MACROS_SVH
`define PER_AGENT_TRANSITION_COUNTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PTC_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PTC_ASSERT(label, prop, msg)
`define PTC_NEVER(label, expr, msg)
`endif
`endif

[rtl/ptc_pkg.sv]
package ptc_pkg;

	localparam int AGENT_W   = 6;
	localparam int STATE_W   = 4;
	localparam int ACT_W     = 3;
	localparam int OUT_CNT_W = 32;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATES = 1'd1;

	localparam logic [CFG_W-1:0] STATES_RESET = 5'd16;

	typedef struct packed {
		logic [AGENT_W-1:0] agent_id;
		logic [STATE_W-1:0] new_state;
		logic [ACT_W-1:0]   action_code;
	} ptc_in_t;

	typedef struct packed {
		logic [STATE_W-1:0]   from_state;
		logic [STATE_W-1:0]   to_state;
		logic                 own_change;
		logic [OUT_CNT_W-1:0] cell_count;
		logic [OUT_CNT_W-1:0] action_count;
		logic                 rejected;
	} ptc_out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREV,
		ST_COUNT
	} ptc_state_t;

endpackage

[rtl/ptc_ram.sv]
module ptc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/ptc_cell_update.sv]
module ptc_cell_update
	import ptc_pkg::*;
#(
	parameter int NUM_ACTIONS = 4,
	parameter int COUNT_BITS  = 32
) (
	input  logic [NUM_ACTIONS+1:0][COUNT_BITS-1:0] row,
	input  logic [ACT_W-1:0]                       action_code,
	input  logic                                   rejected,
	output logic [NUM_ACTIONS+1:0][COUNT_BITS-1:0] new_row,
	output logic                                   own_change,
	output logic [COUNT_BITS-1:0]                  cell_count,
	output logic [COUNT_BITS-1:0]                  action_count
);

	// Row layout: field 0 own count, field 1 external count, field k+1 action k.
	logic                  own;
	logic [COUNT_BITS-1:0] cc_old;
	logic [COUNT_BITS-1:0] cc_new;
	logic [COUNT_BITS-1:0] ac_old;
	logic [COUNT_BITS-1:0] ac_new;

	assign own = (action_code != '0);

	always_comb begin
		cc_old = own ? row[0] : row[1];
		ac_old = '0;
		for (int k = 1; k <= NUM_ACTIONS; k++) begin
			if (32'(action_code) == k) begin
				ac_old = row[k+1];
			end
		end
		// hold at the top instead of wrapping
		cc_new = (cc_old == '1) ? cc_old : cc_old + 1'b1;
		ac_new = (ac_old == '1) ? ac_old : ac_old + 1'b1;

		new_row = row;
		if (!rejected) begin
			if (own) begin
				new_row[0] = cc_new;
				for (int k = 1; k <= NUM_ACTIONS; k++) begin
					if (32'(action_code) == k) begin
						new_row[k+1] = ac_new;
					end
				end
			end else begin
				new_row[1] = cc_new;
			end
		end

		own_change   = own && !rejected;
		cell_count   = rejected ? '0 : cc_new;
		action_count = (rejected || !own) ? '0 : ac_new;
	end

endmodule

[rtl/per_agent_transition_counter_core.sv]
// Transition count histogram over a population of agents. Each beat on the input
// reports an agent's new state and the action behind it (zero for an outside change);
// the core looks up that agent's previous state, bumps the saturating counts of the
// (previous, new) cell and returns the cell with its new counts. A beat whose new
// state is not below states_in_use, or whose action code is above NUM_ACTIONS, comes
// back flagged as rejected and changes nothing; while enable is low beats are taken
// and dropped without a result. An enabled beat reads the agent's previous state from
// its memory as it is taken, then reads the cell's count row, then writes the updated
// row back and loads the output register, stalling there until that register is free.
// The next beat is taken while a result still waits in the output register. After
// reset in_ready stays low while both memories are swept to zero; configuration
// writes are taken during that sweep.
`include "per_agent_transition_counter_core_macros.svh"

module per_agent_transition_counter_core
	import ptc_pkg::*;
#(
	parameter int MAX_STATES  = 16,
	parameter int NUM_AGENTS  = 64,
	parameter int NUM_ACTIONS = 4,
	parameter int COUNT_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  ptc_in_t              in_data,

	output logic                 out_valid,
	input  logic                 out_ready,
	output ptc_out_t             out_data,

	input  logic                 cfg_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int Cells     = MAX_STATES * MAX_STATES;
	localparam int CellW     = $clog2(Cells);
	localparam int AgentW    = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
	localparam int AgentSpan = 2 ** AGENT_W;
	localparam int ClearLen  = (Cells > NUM_AGENTS) ? Cells : NUM_AGENTS;
	localparam int ClrW      = $clog2(ClearLen);
	localparam int RowW      = (NUM_ACTIONS + 2) * COUNT_BITS;
	localparam int ProdW     = STATE_W + CFG_W + 1;

	ptc_state_t state_q, state_d;

	logic [ClrW-1:0]    clr_q;
	logic               enable_q;
	logic [CFG_W-1:0]   states_q;

	logic [AgentW-1:0]  agent_s1;
	logic [STATE_W-1:0] to_s1;
	logic [ACT_W-1:0]   act_s1;
	logic [STATE_W-1:0] from_s2;
	logic               reject_s2;
	logic [CellW-1:0]   cell_s2;

	logic               out_valid_q;
	ptc_out_t           out_q;

	logic               accept;
	logic               out_free;
	logic               load_out;
	logic               clr_adv;
	logic               prev_we;
	logic               cnt_we;

	logic [AgentW-1:0]  agent_map [AgentSpan];
	logic [AgentW-1:0]  prev_waddr;
	logic [STATE_W-1:0] prev_wdata;
	logic [STATE_W-1:0] prev_rdata;

	logic [CellW-1:0]   cnt_waddr;
	logic [CellW-1:0]   cnt_raddr;
	logic [RowW-1:0]    cnt_wdata;
	logic [RowW-1:0]    cnt_rdata;

	logic [CFG_W-1:0]   n_eff;
	logic               reject_c;
	logic [ProdW-1:0]   cell_wide;
	logic [CellW-1:0]   cell_c;

	logic [NUM_ACTIONS+1:0][COUNT_BITS-1:0] row_new;
	logic                                   upd_own;
	logic [COUNT_BITS-1:0]                  upd_cc;
	logic [COUNT_BITS-1:0]                  upd_ac;

	// Agent index folded into range, worked out at elaboration.
	for (genvar g = 0; g < AgentSpan; g++) begin : g_agent_map
		assign agent_map[g] = AgentW'(g % NUM_AGENTS);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			states_q <= STATES_RESET;
		end else if (cfg_en) begin
			case (cfg_addr)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_STATES: states_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (states_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (32'(states_q) > MAX_STATES) begin
			n_eff = CFG_W'(MAX_STATES);
		end else begin
			n_eff = states_q;
		end
	end

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// A stored previous state is always below MAX_STATES, so the cell index
	// from * n + to never leaves the count memory.
	assign reject_c  = (32'(to_s1) >= 32'(n_eff)) || (32'(act_s1) > NUM_ACTIONS);
	assign cell_wide = ProdW'(prev_rdata) * ProdW'(n_eff) + ProdW'(to_s1);
	assign cell_c    = CellW'(cell_wide);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_adv) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		clr_adv  = 1'b0;
		prev_we  = 1'b0;
		cnt_we   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clr_adv = 1'b1;
				cnt_we  = 1'b1;
				prev_we = (32'(clr_q) < NUM_AGENTS);
				if (32'(clr_q) == ClearLen - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && enable_q) begin
					state_d = ST_PREV;
				end
			end
			ST_PREV: begin
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				// stall the write-back until the output register frees up
				if (out_free) begin
					load_out = 1'b1;
					cnt_we   = !reject_s2;
					prev_we  = !reject_s2;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			agent_s1 <= agent_map[in_data.agent_id];
			to_s1    <= in_data.new_state;
			act_s1   <= in_data.action_code;
		end
		if (state_q == ST_PREV) begin
			from_s2   <= prev_rdata;
			reject_s2 <= reject_c;
			cell_s2   <= cell_c;
		end
	end

	assign prev_waddr = (state_q == ST_CLEAR) ? clr_q[AgentW-1:0] : agent_s1;
	assign prev_wdata = (state_q == ST_CLEAR) ? '0 : to_s1;

	ptc_ram #(
		.WIDTH (STATE_W),
		.DEPTH (NUM_AGENTS)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (agent_map[in_data.agent_id]),
		.rdata (prev_rdata)
	);

	// Hold the row address while the write-back stalls so the read data stays put.
	assign cnt_raddr = (state_q == ST_PREV) ? cell_c : cell_s2;
	assign cnt_waddr = (state_q == ST_CLEAR) ? clr_q[CellW-1:0] : cell_s2;
	assign cnt_wdata = (state_q == ST_CLEAR) ? '0 : row_new;

	ptc_ram #(
		.WIDTH (RowW),
		.DEPTH (Cells)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	ptc_cell_update #(
		.NUM_ACTIONS (NUM_ACTIONS),
		.COUNT_BITS  (COUNT_BITS)
	) u_update (
		.row          (cnt_rdata),
		.action_code  (act_s1),
		.rejected     (reject_s2),
		.new_row      (row_new),
		.own_change   (upd_own),
		.cell_count   (upd_cc),
		.action_count (upd_ac)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.from_state   <= from_s2;
			out_q.to_state     <= to_s1;
			out_q.own_change   <= upd_own;
			out_q.cell_count   <= OUT_CNT_W'(64'(upd_cc));
			out_q.action_count <= OUT_CNT_W'(64'(upd_ac));
			out_q.rejected     <= reject_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PTC_ASSERT(a_load_from_count, $rose(out_valid_q) |-> $past(state_q == ST_COUNT), "result loaded outside write-back")
	`PTC_ASSERT(a_reject_clean, out_valid && out_data.rejected |-> !out_data.own_change && out_data.cell_count == '0 && out_data.action_count == '0, "rejected result carries counts")
	`PTC_ASSERT(a_external_no_action, out_valid && !out_data.own_change |-> out_data.action_count == '0, "external result carries an action count")
	`PTC_NEVER(a_write_while_idle, (cnt_we || prev_we) && (state_q == ST_IDLE || state_q == ST_PREV), "memory written outside clear or write-back")

endmodule

[test/per_agent_transition_counter_core_test.sv]
module per_agent_transition_counter_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ptc_pkg::*;

	localparam int MAX_ST   = 16;
	localparam int N_AGENTS = 64;
	localparam int N_ACT    = 4;
	localparam int CELLS    = MAX_ST * MAX_ST;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	ptc_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	ptc_out_t             out_data;
	logic                 cfg_en    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr  = REG_ENABLE;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// transition counter state as the block should hold it
	bit [STATE_W-1:0]   last_state     [N_AGENTS];
	bit [OUT_CNT_W-1:0] own_count      [CELLS];
	bit [OUT_CNT_W-1:0] external_count [CELLS];
	bit [OUT_CNT_W-1:0] action_count   [N_ACT * CELLS];
	bit                 cfg_enable = 1'b1;
	bit [CFG_W-1:0]     cfg_states = STATES_RESET;

	ptc_in_t     report_queue[$];
	ptc_out_t    predicted_results[$];
	bit          report_held = 1'b0;
	bit          steady      = 1'b0;
	int unsigned send_wait;
	int unsigned stall_left;
	int unsigned mismatch_count = 0;
	ptc_out_t    next_result;
	ptc_out_t    got_beat;
	ptc_out_t    want_beat;

	per_agent_transition_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_en    (cfg_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t mismatch on %s: got %0h, predicted %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// mostly back to back, sometimes a short pause, rarely a long pause
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int unsigned effective_states();
		if (cfg_states == 0) return 1;
		if (cfg_states > MAX_ST) return MAX_ST;
		return cfg_states;
	endfunction

	function automatic bit [OUT_CNT_W-1:0] saturating_inc(bit [OUT_CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic bit count_transition(input ptc_in_t beat, output ptc_out_t res);
		int unsigned n;
		int unsigned from;
		int unsigned to;
		int unsigned act;
		int unsigned cell_idx;
		int unsigned slot;
		res = '0;
		if (!cfg_enable) return 1'b0;
		n = effective_states();
		from = last_state[beat.agent_id];
		to = beat.new_state;
		act = beat.action_code;
		res.from_state = STATE_W'(from);
		res.to_state = beat.new_state;
		if (to >= n || act > N_ACT) begin
			res.rejected = 1'b1;
			return 1'b1;
		end
		// a stale previous state above n can alias into another row
		cell_idx = (from * n + to) % CELLS;
		if (act != 0) begin
			slot = (act - 1) * CELLS + cell_idx;
			own_count[cell_idx] = saturating_inc(own_count[cell_idx]);
			action_count[slot] = saturating_inc(action_count[slot]);
			res.own_change = 1'b1;
			res.cell_count = own_count[cell_idx];
			res.action_count = action_count[slot];
		end else begin
			external_count[cell_idx] = saturating_inc(external_count[cell_idx]);
			res.cell_count = external_count[cell_idx];
		end
		last_state[beat.agent_id] = beat.new_state;
		return 1'b1;
	endfunction

	function automatic ptc_in_t random_report();
		ptc_in_t r;
		int unsigned n;
		n = effective_states();
		// half the beats go to a few hot agents so their cells build up counts
		r.agent_id = ($urandom_range(0, 1) == 0) ? AGENT_W'($urandom_range(0, 3))
			: AGENT_W'($urandom_range(0, N_AGENTS - 1));
		r.new_state = ($urandom_range(0, 9) < 8) ? STATE_W'($urandom_range(0, n - 1))
			: STATE_W'($urandom_range(0, 15));
		r.action_code = ($urandom_range(0, 9) < 9) ? ACT_W'($urandom_range(0, N_ACT))
			: ACT_W'($urandom_range(0, 7));
		return r;
	endfunction

	task automatic push_report(int unsigned agent, int unsigned state, int unsigned act);
		ptc_in_t r;
		r.agent_id = AGENT_W'(agent);
		r.new_state = STATE_W'(state);
		r.action_code = ACT_W'(act);
		report_queue = {report_queue, r};
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_en <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_en <= 1'b0;
		if (idx == REG_ENABLE)
			cfg_enable = val[0];
		else
			cfg_states = val;
	endtask

	// wait for all beats to go in and all results to come out, then let a dropped beat clear
	task automatic drain();
		int unsigned guard;
		guard = 0;
		while ((report_queue.size() != 0 || report_held || predicted_results.size() != 0)
				&& guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic run_phase(bit en, int unsigned states, int unsigned beats, bit calm);
		write_reg(REG_ENABLE, CFG_W'(en));
		write_reg(REG_STATES, CFG_W'(states));
		steady = calm;
		repeat (beats) report_queue = {report_queue, random_report()};
		drain();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (count_transition(in_data, next_result))
					predicted_results = {predicted_results, next_result};
				report_held = 1'b0;
			end
			if (!report_held) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (report_queue.size() != 0) begin
					in_data <= report_queue.pop_front();
					in_valid <= 1'b1;
					report_held = 1'b1;
					send_wait = steady ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got_beat = out_data;
				if (predicted_results.size() == 0) begin
					report_mismatch("result beat with nothing pending",
						64'(got_beat.cell_count), 0);
				end else begin
					want_beat = predicted_results.pop_front();
					if (got_beat.from_state !== want_beat.from_state)
						report_mismatch("from_state", got_beat.from_state, want_beat.from_state);
					if (got_beat.to_state !== want_beat.to_state)
						report_mismatch("to_state", got_beat.to_state, want_beat.to_state);
					if (got_beat.own_change !== want_beat.own_change)
						report_mismatch("own_change", got_beat.own_change, want_beat.own_change);
					if (got_beat.cell_count !== want_beat.cell_count)
						report_mismatch("cell_count", got_beat.cell_count, want_beat.cell_count);
					if (got_beat.action_count !== want_beat.action_count)
						report_mismatch("action_count", got_beat.action_count,
							want_beat.action_count);
					if (got_beat.rejected !== want_beat.rejected)
						report_mismatch("rejected", got_beat.rejected, want_beat.rejected);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = steady ? 0 : idle_len();
			end
		end
	end

	initial begin
		#6ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: full state range, every action, bad action codes, repeated cells
		write_reg(REG_ENABLE, CFG_W'(1));
		write_reg(REG_STATES, CFG_W'(16));
		push_report(0, 15, 0);
		push_report(0, 15, 0);
		push_report(0, 15, 0);
		push_report(63, 0, 4);
		push_report(63, 0, 4);
		push_report(63, 5, 1);
		push_report(63, 5, 2);
		push_report(63, 5, 3);
		push_report(63, 5, 4);
		push_report(42, 10, 5);
		push_report(21, 7, 7);
		push_report(21, 7, 6);
		push_report(42, 10, 0);
		push_report(21, 10, 3);
		push_report(42, 0, 0);
		push_report(63, 15, 4);
		push_report(0, 0, 2);
		push_report(0, 15, 1);
		push_report(0, 15, 1);
		push_report(42, 15, 0);
		drain();

		run_phase(1'b1, 31, 300, 1'b0);
		run_phase(1'b1, 0, 120, 1'b0);
		run_phase(1'b1, 1, 100, 1'b1);
		run_phase(1'b1, 5, 300, 1'b0);
		// dropped beats: no results, nothing updated
		run_phase(1'b0, 5, 60, 1'b0);
		run_phase(1'b1, 17, 250, 1'b0);
		run_phase(1'b1, 16, 350, 1'b1);
		run_phase(1'b1, 2, 150, 1'b0);
		run_phase(1'b1, 9, 280, 1'b0);

		if (predicted_results.size() != 0)
			report_mismatch("results never delivered", predicted_results.size(), 0);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_ram.sv
rtl/ptc_cell_update.sv
rtl/per_agent_transition_counter_core.sv
test/per_agent_transition_counter_core_test.sv
